// ===== rtl/core/cha_pkg.sv =====
`timescale 1ns / 1ps
package cha_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int STEP_MAX         = 24;
  localparam int LANES            = 4;
  localparam int STEP_IDX_W       = 5;

  localparam int IN_W    = 16;
  localparam int XY_W    = 19;
  localparam int ACC_W   = 26;
  localparam int HEAD_W  = 15;
  localparam int OFF_W   = 16;
  localparam int ATAN_W  = 22;

  localparam int TURN_UNITS   = 23040;
  localparam int OFFSET_LIMIT = 23039;
  localparam int ACC_180      = 11796480;
  localparam int ACC_360      = 23592960;
  localparam int ROUND_BIAS   = 512;
  localparam int ROUND_SHIFT  = 10;

  localparam int QUEUE_DEPTH = 2;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET = 2'd1;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_OFF  = 2'd1,
    ST_BUS  = 2'd2,
    ST_ZERO = 2'd3
  } status_t;

  typedef struct packed {
    status_t                 status;
    logic                    flip;
    logic signed [XY_W-1:0]  x;
    logic signed [XY_W-1:0]  y;
  } cha_item_t;

  function automatic logic [ATAN_W-1:0] atan_lut(input logic [STEP_IDX_W-1:0] i);
    logic [ATAN_W-1:0] v;
    case (i)
      5'd0:    v = 22'd2949120;
      5'd1:    v = 22'd1740967;
      5'd2:    v = 22'd919879;
      5'd3:    v = 22'd466945;
      5'd4:    v = 22'd234379;
      5'd5:    v = 22'd117304;
      5'd6:    v = 22'd58666;
      5'd7:    v = 22'd29335;
      5'd8:    v = 22'd14668;
      5'd9:    v = 22'd7334;
      5'd10:   v = 22'd3667;
      5'd11:   v = 22'd1833;
      5'd12:   v = 22'd917;
      5'd13:   v = 22'd458;
      5'd14:   v = 22'd229;
      5'd15:   v = 22'd115;
      5'd16:   v = 22'd57;
      5'd17:   v = 22'd29;
      5'd18:   v = 22'd14;
      5'd19:   v = 22'd7;
      5'd20:   v = 22'd4;
      5'd21:   v = 22'd2;
      5'd22:   v = 22'd1;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/core/cha_front.sv =====
`timescale 1ns / 1ps
module cha_front (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [cha_pkg::IN_W-1:0]    x_reading,
  input  logic signed [cha_pkg::IN_W-1:0]    y_reading,
  input  logic                               bus_error,
  input  logic                               enable,
  input  logic                               err_clear,
  input  logic                               q_full,
  output logic                               push,
  output cha_pkg::cha_item_t                 item
);
  import cha_pkg::*;

  logic    error_latched;
  logic    flip;
  status_t st;
  logic signed [XY_W-1:0] xe;
  logic signed [XY_W-1:0] ye;

  assign in_ready = !q_full;
  assign push     = in_valid && in_ready;

  always_comb begin
    if (!enable || error_latched) begin
      st = ST_OFF;
    end else if (bus_error) begin
      st = ST_BUS;
    end else if (x_reading == '0 && y_reading == '0) begin
      st = ST_ZERO;
    end else begin
      st = ST_OK;
    end
  end

  assign flip = x_reading < 0;
  assign xe   = XY_W'(x_reading);
  assign ye   = XY_W'(y_reading);

  always_comb begin
    item.status = st;
    item.flip   = flip;
    item.x      = flip ? -xe : xe;
    item.y      = flip ? -ye : ye;
  end

  // latch on a bus error, clear on any enable write
  always_ff @(posedge clk) begin
    if (rst) begin
      error_latched <= 1'b0;
    end else if (err_clear) begin
      error_latched <= 1'b0;
    end else if (push && st == ST_BUS) begin
      error_latched <= 1'b1;
    end
  end

endmodule

// ===== rtl/core/cha_queue.sv =====
`timescale 1ns / 1ps
module cha_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  cha_pkg::cha_item_t  push_item,
  output logic                full,
  output logic                head_valid,
  input  logic                pop,
  output cha_pkg::cha_item_t  head_item
);
  import cha_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cha_item_t        mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full       = count == CNT_W'(QUEUE_DEPTH);
  assign head_valid = count != '0;
  assign head_item  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/cha_back.sv =====
`timescale 1ns / 1ps
module cha_back #(
  parameter int CORDIC_STEPS = cha_pkg::CORDIC_STEPS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               q_valid,
  output logic                               q_pop,
  input  cha_pkg::cha_item_t                 q_item,
  input  logic signed [cha_pkg::OFF_W-1:0]   offset,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [cha_pkg::HEAD_W-1:0]         heading,
  output logic [1:0]                         status
);
  import cha_pkg::*;

  localparam int PASSES = (CORDIC_STEPS + LANES - 1) / LANES;
  localparam int CNT_W  = $clog2(PASSES + 1);
  localparam int SUM_W  = HEAD_W + 2;

  typedef struct packed {
    logic signed [XY_W-1:0]  x;
    logic signed [XY_W-1:0]  y;
    logic signed [ACC_W-1:0] acc;
  } cord_t;

  function automatic cord_t cordic_pass(input cord_t c_in, input logic [STEP_IDX_W-1:0] base);
    cord_t c;
    logic signed [XY_W-1:0]  xs;
    logic signed [XY_W-1:0]  ys;
    logic signed [ACC_W-1:0] ang;
    int k;
    c = c_in;
    for (int j = 0; j < LANES; j++) begin
      k = int'(base) + j;
      if (k < CORDIC_STEPS && k < STEP_MAX) begin
        xs  = c.x >>> k;
        ys  = c.y >>> k;
        ang = $signed(ACC_W'(atan_lut(STEP_IDX_W'(k))));
        if (c.y < 0) begin
          c.x   = c.x - ys;
          c.y   = c.y + xs;
          c.acc = c.acc - ang;
        end else begin
          c.x   = c.x + ys;
          c.y   = c.y - xs;
          c.acc = c.acc + ang;
        end
      end
    end
    return c;
  endfunction

  cord_t                  work;
  status_t                work_status;
  logic                   busy;
  logic [CNT_W-1:0]       cnt;
  cord_t                  pass_in;
  cord_t                  pass_out;
  logic [STEP_IDX_W-1:0]  pass_base;
  logic                   done;
  logic                   it_move;

  logic                   r_valid;
  logic [HEAD_W-1:0]      r_raw;
  status_t                r_status;
  logic                   r_move;
  logic                   r_free;
  logic                   out_free;

  logic signed [ACC_W-1:0] acc_pos;
  logic signed [ACC_W-1:0] acc_rnd;
  logic [HEAD_W:0]         raw_q;
  logic [HEAD_W-1:0]       raw_next;

  logic signed [SUM_W-1:0] sum;
  logic signed [SUM_W-1:0] sum_wrap;

  assign out_free = !out_valid || out_ready;
  assign r_move   = r_valid && out_free;
  assign r_free   = !r_valid || r_move;
  assign done     = busy && cnt == CNT_W'(PASSES);
  assign it_move  = done && r_free;
  assign q_pop    = q_valid && (!busy || it_move);

  always_comb begin
    if (q_pop) begin
      pass_in.x   = q_item.x;
      pass_in.y   = q_item.y;
      pass_in.acc = q_item.flip ? ACC_W'(ACC_180) : '0;
      pass_base   = '0;
    end else begin
      pass_in     = work;
      pass_base   = STEP_IDX_W'(int'(cnt) * LANES);
    end
    pass_out = cordic_pass(pass_in, pass_base);
  end

  always_ff @(posedge clk) begin
    if (q_pop || (busy && !done)) begin
      work <= pass_out;
    end
    if (q_pop) begin
      work_status <= q_item.status;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (q_pop) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(1);
    end else if (it_move) begin
      busy <= 1'b0;
    end else if (busy && !done) begin
      cnt  <= cnt + 1'b1;
    end
  end

  always_comb begin
    acc_pos = (work.acc < 0) ? work.acc + ACC_W'(ACC_360) : work.acc;
    acc_rnd = (acc_pos + ACC_W'(ROUND_BIAS)) >>> ROUND_SHIFT;
    raw_q   = acc_rnd[HEAD_W:0];
    if (raw_q >= (HEAD_W + 1)'(TURN_UNITS)) begin
      raw_q = raw_q - (HEAD_W + 1)'(TURN_UNITS);
    end
    raw_next = (work_status == ST_OK) ? raw_q[HEAD_W-1:0] : '0;
  end

  always_ff @(posedge clk) begin
    if (it_move) begin
      r_raw    <= raw_next;
      r_status <= work_status;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid <= 1'b0;
    end else if (it_move) begin
      r_valid <= 1'b1;
    end else if (r_move) begin
      r_valid <= 1'b0;
    end
  end

  always_comb begin
    sum = $signed({2'b00, r_raw}) + SUM_W'(offset);
    if (sum < 0) begin
      sum_wrap = sum + SUM_W'(TURN_UNITS);
    end else if (sum >= SUM_W'(TURN_UNITS)) begin
      sum_wrap = sum - SUM_W'(TURN_UNITS);
    end else begin
      sum_wrap = sum;
    end
  end

  always_ff @(posedge clk) begin
    if (r_move) begin
      heading <= (r_status == ST_OFF) ? '0 : sum_wrap[HEAD_W-1:0];
      status  <= r_status;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (r_move) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// ===== rtl/core/compass_heading_atan2.sv =====
`timescale 1ns / 1ps
// Compass heading from one two-axis sensor sample.
// s_axis: one word per sample, tdata = {y_reading, x_reading} (signed 16-bit each),
//   tuser = bus_error. m_axis: one word per sample, tdata[14:0] = heading in
//   1/64 degree (0..23039), tuser = status (0 ok, 1 disabled or error latched,
//   2 bus error now, 3 zero vector).
// cfg: index 0 = enable (bit 0, any write clears the error flag), index 1 =
//   signed heading offset in 1/64 degree. Always ready; write only while idle.
// A sample passes the classifying front end into a two-word queue, then a CORDIC
//   unit doing four steps per cycle, a rounding stage and the output register.
// The CORDIC unit sets the sample rate: it works on one sample at a time and takes the
//   next from the queue as it hands its result to the rounding stage.
// Reset clears the error flag, enable and offset, and empties every stage.
// When m_axis_tready is low the output word holds, the stages behind it fill,
//   and s_axis_tready drops once the queue is full.
module compass_heading_atan2 #(
  parameter int CORDIC_STEPS = cha_pkg::CORDIC_STEPS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [31:0]                       s_axis_tdata,   // x_reading, y_reading
  input  logic                              s_axis_tuser,   // bus_error
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [15:0]                       m_axis_tdata,   // heading, pad
  output logic [1:0]                        m_axis_tuser,   // status
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [cha_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [cha_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import cha_pkg::*;

  logic                     enable;
  logic signed [OFF_W-1:0]  offset_sat;
  logic signed [OFF_W-1:0]  cfg_signed;
  logic                     cfg_write;
  logic                     err_clear;

  logic                     push;
  logic                     q_full;
  logic                     q_valid;
  logic                     q_pop;
  cha_item_t                push_item;
  cha_item_t                head_item;
  logic [HEAD_W-1:0]        heading;

  assign cfg_ready  = 1'b1;
  assign cfg_write  = cfg_valid && cfg_ready;
  assign err_clear  = cfg_write && cfg_index == CFG_ENABLE;
  assign cfg_signed = $signed(cfg_data[OFF_W-1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      enable     <= 1'b0;
      offset_sat <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_ENABLE: begin
          enable <= cfg_data[0];
        end
        CFG_OFFSET: begin
          if (cfg_signed > OFF_W'(OFFSET_LIMIT)) begin
            offset_sat <= OFF_W'(OFFSET_LIMIT);
          end else if (cfg_signed < -OFF_W'(OFFSET_LIMIT)) begin
            offset_sat <= -OFF_W'(OFFSET_LIMIT);
          end else begin
            offset_sat <= cfg_signed;
          end
        end
        default: begin
        end
      endcase
    end
  end

  cha_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .x_reading ($signed(s_axis_tdata[15:0])),
    .y_reading ($signed(s_axis_tdata[31:16])),
    .bus_error (s_axis_tuser),
    .enable    (enable),
    .err_clear (err_clear),
    .q_full    (q_full),
    .push      (push),
    .item      (push_item)
  );

  cha_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .full       (q_full),
    .head_valid (q_valid),
    .pop        (q_pop),
    .head_item  (head_item)
  );

  cha_back #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_item    (head_item),
    .offset    (offset_sat),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .heading   (heading),
    .status    (m_axis_tuser)
  );

  assign m_axis_tdata = {1'b0, heading};

endmodule

// ===== rtl/core/cha_check.sv =====
`timescale 1ns / 1ps
module cha_check (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);
  import cha_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("output word changed while stalled");

  a_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata < 16'(TURN_UNITS))
    else $error("heading outside one turn");

  a_off_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser == ST_OFF |-> m_axis_tdata == '0)
    else $error("disabled word with non-zero heading");

  a_reset: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid right after reset");

endmodule

bind compass_heading_atan2 cha_check u_cha_check (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
